FILE: hw/rtl/morton_texture_span_sampler_macros.svh
// Assertion macros shared by the checker of the Morton texture span sampler.
// Depends on nothing; included by the checker file.
`ifndef MORTON_TEXTURE_SPAN_SAMPLER_MACROS_SVH
`define MORTON_TEXTURE_SPAN_SAMPLER_MACROS_SVH

// The consequent must hold in the cycle after the antecedent, outside reset.
`define MTSS_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("mtss: next-cycle property failed");

// Same, but also checked across reset.
`define MTSS_ASSERT_NEXT_ALWAYS(label, clk, ante, cons) \
   label: assert property (@(posedge clk) (ante) |=> (cons)) \
      else $error("mtss: next-cycle property failed");

`endif

FILE: hw/rtl/mtss_pkg.sv
// Shared types and constants of the Morton texture span sampler.
// No dependencies; used by the top level, its checker and the testbench.
`timescale 1ns / 1ps

package mtss_pkg;

   localparam int unsigned FUNC_BITS       = 2;
   localparam int unsigned TEXEL_POS_BITS  = 10;
   localparam int unsigned VALUE_BITS      = 8;
   localparam int unsigned WORD_BITS       = 32;
   localparam int unsigned CSR_INDEX_BITS  = 2;
   localparam int unsigned FRAC_BITS       = 12;
   localparam int unsigned TEXELS_PER_ROW  = 8;
   localparam int unsigned MAX_PENDING     = 2;

   localparam logic [WORD_BITS-1:0] FRAC_MASK = 32'h0000_0fff;
   localparam logic [WORD_BITS-1:0] U_PAD     = 32'haaaa_a000;
   localparam logic [WORD_BITS-1:0] V_PAD     = 32'h5555_5000;

   typedef enum logic [FUNC_BITS-1:0] {
      FUNC_WRITE = 2'd0,
      FUNC_START = 2'd1,
      FUNC_ROW   = 2'd2
   } func_type;

   typedef enum logic [CSR_INDEX_BITS-1:0] {
      CSR_PIXEL_STEP_U = 2'd0,
      CSR_PIXEL_STEP_V = 2'd1,
      CSR_ROW_STEP_U   = 2'd2,
      CSR_ROW_STEP_V   = 2'd3
   } csr_index_type;

endpackage

FILE: hw/rtl/morton_texture_span_sampler.sv
// Rotozoom sampler over a byte texture held in Morton order in one RAM.
// Depends on mtss_pkg.
//
// Channel  Ports   Direction  Carries
// req      req_*   in         write texel, load span start, or emit a row
// rsp      rsp_*   out        eight sampled texels packed in two words
// csr      csr_*   in         pixel and row steps, 20.12 two's complement
//
// A row request holds the single texture RAM port while its eight texels
// are read in turn; the next row may come as the last of those reads issues.
// Reads pass the lane-sum and RAM data registers into the gather buffer.
// Writes wait until reads of earlier rows have issued; span loads never do.
// Reset clears registers only; the texture stays undefined until written.
// A finished row waits in the output register, with one more in the gather
// buffer; row requests stall while two rows are outstanding.
`timescale 1ns / 1ps

module morton_texture_span_sampler #(
   parameter int unsigned AXIS_BITS = 10
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic [mtss_pkg::FUNC_BITS-1:0]      req_func,
   input  logic [mtss_pkg::TEXEL_POS_BITS-1:0] req_texel_u,
   input  logic [mtss_pkg::TEXEL_POS_BITS-1:0] req_texel_v,
   input  logic [mtss_pkg::VALUE_BITS-1:0]     req_texel_value,
   input  logic signed [mtss_pkg::WORD_BITS-1:0] req_start_u,
   input  logic signed [mtss_pkg::WORD_BITS-1:0] req_start_v,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic [mtss_pkg::WORD_BITS-1:0]      rsp_row_word_low,
   output logic [mtss_pkg::WORD_BITS-1:0]      rsp_row_word_high,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [mtss_pkg::CSR_INDEX_BITS-1:0] csr_index,
   input  logic [mtss_pkg::WORD_BITS-1:0]      csr_data
);
   import mtss_pkg::*;

   localparam int unsigned ADDR_BITS  = 2 * AXIS_BITS;
   localparam int unsigned DEPTH      = 1 << ADDR_BITS;
   localparam int unsigned COUNT_BITS = $clog2(TEXELS_PER_ROW);
   localparam int unsigned ROW_BITS   = TEXELS_PER_ROW * VALUE_BITS;
   localparam int unsigned LANE_U     = 0;
   localparam int unsigned LANE_V     = 1;

   // Spread the low AXIS_BITS integer bits of a 20.12 value onto every other
   // bit above the fraction; the v lane sits one bit higher than the u lane.
   function automatic logic [WORD_BITS-1:0] to_lane(input logic [WORD_BITS-1:0] lin,
                                                    input int unsigned lane);
      logic [WORD_BITS-1:0] r;
      r = lin & FRAC_MASK;
      for (int i = 0; i < AXIS_BITS; i++) begin
         r[FRAC_BITS + 2 * i + lane] = lin[FRAC_BITS + i];
      end
      return r;
   endfunction

   function automatic logic [ADDR_BITS-1:0] morton(input logic [TEXEL_POS_BITS-1:0] tu,
                                                   input logic [TEXEL_POS_BITS-1:0] tv);
      logic [ADDR_BITS-1:0] r;
      r = '0;
      for (int i = 0; i < AXIS_BITS; i++) begin
         r[2 * i]     = tu[i];
         r[2 * i + 1] = tv[i];
      end
      return r;
   endfunction

   localparam logic [WORD_BITS-1:0] U_MASK = to_lane('1, LANE_U);
   localparam logic [WORD_BITS-1:0] V_MASK = to_lane('1, LANE_V);

   // Configuration and accumulators.
   logic [WORD_BITS-1:0] pix_step_u_ff, pix_step_v_ff, row_step_u_ff, row_step_v_ff;
   logic [WORD_BITS-1:0] acc_u_ff, acc_v_ff, acc_u_in, acc_v_in;

   // Texel read sequencer.
   logic                  seq_active_ff, seq_active_in;
   logic [COUNT_BITS-1:0] seq_count_ff, seq_count_in;
   logic [WORD_BITS-1:0]  base_u_ff, base_u_in, base_v_ff, base_v_in;
   logic [WORD_BITS-1:0]  ofs_u_ff, ofs_u_in, ofs_v_ff, ofs_v_in;
   logic                  seq_last;

   // Lane sums ahead of the address add, then RAM read data.
   logic                 s1_valid_ff, s1_last_ff;
   logic [WORD_BITS-1:0] s1_ua_ff, s1_va_ff, s1_ua_in, s1_va_in;
   logic                 rd_valid_ff, rd_last_ff;
   logic [VALUE_BITS-1:0] rdata_ff;

   // Row assembly and output.
   logic [ROW_BITS-1:0]  gather_ff, gather_in;
   logic                 gather_full_ff, gather_full_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic [WORD_BITS-1:0] rsp_low_ff, rsp_high_ff;
   logic [1:0]           pending_ff, pending_in;
   logic                 move;

   logic [VALUE_BITS-1:0] tex_mem [DEPTH];
   logic [WORD_BITS-1:0]  addr_sum;
   logic [ADDR_BITS-1:0]  mem_addr;

   logic row_ok, write_ok, accept, is_write, is_start, is_row, csr_write;

   assign seq_last = seq_count_ff == COUNT_BITS'(TEXELS_PER_ROW - 1);
   assign row_ok   = (!seq_active_ff || seq_last) && (pending_ff < 2'(MAX_PENDING));
   // A write must not overtake the reads of a row taken earlier.
   assign write_ok = !seq_active_ff && !s1_valid_ff;

   always_comb begin
      unique case (req_func)
         FUNC_WRITE: req_ready = write_ok && !reset;
         FUNC_ROW:   req_ready = row_ok && !reset;
         default:    req_ready = !reset;
      endcase
   end

   assign accept    = req_valid && req_ready;
   assign is_write  = accept && (req_func == FUNC_WRITE);
   assign is_start  = accept && (req_func == FUNC_START);
   assign is_row    = accept && (req_func == FUNC_ROW);
   assign csr_ready = !reset;
   assign csr_write = csr_valid && csr_ready;

   // The accumulators advance by the row step as soon as a row is taken;
   // the sequencer works from its own copy of the start.
   always_comb begin
      acc_u_in = acc_u_ff;
      acc_v_in = acc_v_ff;
      if (is_start) begin
         acc_u_in = to_lane(req_start_u, LANE_U);
         acc_v_in = to_lane(req_start_v, LANE_V);
      end else if (is_row) begin
         acc_u_in = (acc_u_ff + (to_lane(row_step_u_ff, LANE_U) | U_PAD)) & U_MASK;
         acc_v_in = (acc_v_ff + (to_lane(row_step_v_ff, LANE_V) | V_PAD)) & V_MASK;
      end
   end

   always_comb begin
      seq_active_in = seq_active_ff;
      seq_count_in  = seq_count_ff;
      base_u_in     = base_u_ff;
      base_v_in     = base_v_ff;
      ofs_u_in      = ofs_u_ff;
      ofs_v_in      = ofs_v_ff;
      if (is_row) begin
         seq_active_in = 1'b1;
         seq_count_in  = '0;
         base_u_in     = acc_u_ff;
         base_v_in     = acc_v_ff;
         ofs_u_in      = '0;
         ofs_v_in      = '0;
      end else if (seq_active_ff) begin
         seq_count_in = seq_count_ff + 1'b1;
         ofs_u_in     = ofs_u_ff + pix_step_u_ff;
         ofs_v_in     = ofs_v_ff + pix_step_v_ff;
         if (seq_last) begin
            seq_active_in = 1'b0;
         end
      end
   end

   // The pad bits of the step let a carry ripple across the other lane.
   assign s1_ua_in = base_u_ff + (to_lane(ofs_u_ff, LANE_U) | U_PAD);
   assign s1_va_in = base_v_ff + (to_lane(ofs_v_ff, LANE_V) | V_PAD);

   // The carry out of the two fractions lands in address bit 0.
   assign addr_sum = (s1_ua_ff & U_MASK) + (s1_va_ff & V_MASK);
   assign mem_addr = s1_valid_ff ? addr_sum[FRAC_BITS +: ADDR_BITS]
                                 : morton(req_texel_u, req_texel_v);

   always_ff @(posedge clock) begin
      if (is_write) begin
         tex_mem[mem_addr] <= req_texel_value;
      end else if (s1_valid_ff) begin
         rdata_ff <= tex_mem[mem_addr];
      end
   end

   assign move           = gather_full_ff && (!rsp_valid_ff || rsp_ready);
   assign gather_in      = rd_valid_ff ? {rdata_ff, gather_ff[ROW_BITS-1:VALUE_BITS]}
                                       : gather_ff;
   assign gather_full_in = (gather_full_ff && !move) || (rd_valid_ff && rd_last_ff);
   assign rsp_valid_in   = move || (rsp_valid_ff && !rsp_ready);

   always_comb begin
      pending_in = pending_ff;
      if (is_row && !(rsp_valid_ff && rsp_ready)) begin
         pending_in = pending_ff + 1'b1;
      end else if (!is_row && rsp_valid_ff && rsp_ready) begin
         pending_in = pending_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pix_step_u_ff  <= '0;
         pix_step_v_ff  <= '0;
         row_step_u_ff  <= '0;
         row_step_v_ff  <= '0;
         acc_u_ff       <= '0;
         acc_v_ff       <= '0;
         seq_active_ff  <= 1'b0;
         seq_count_ff   <= '0;
         s1_valid_ff    <= 1'b0;
         rd_valid_ff    <= 1'b0;
         gather_full_ff <= 1'b0;
         rsp_valid_ff   <= 1'b0;
         pending_ff     <= '0;
      end else begin
         if (csr_write) begin
            unique case (csr_index)
               CSR_PIXEL_STEP_U: pix_step_u_ff <= csr_data;
               CSR_PIXEL_STEP_V: pix_step_v_ff <= csr_data;
               CSR_ROW_STEP_U:   row_step_u_ff <= csr_data;
               CSR_ROW_STEP_V:   row_step_v_ff <= csr_data;
               default:          pix_step_u_ff <= pix_step_u_ff;
            endcase
         end
         acc_u_ff       <= acc_u_in;
         acc_v_ff       <= acc_v_in;
         seq_active_ff  <= seq_active_in;
         seq_count_ff   <= seq_count_in;
         s1_valid_ff    <= seq_active_ff;
         rd_valid_ff    <= s1_valid_ff;
         gather_full_ff <= gather_full_in;
         rsp_valid_ff   <= rsp_valid_in;
         pending_ff     <= pending_in;
      end
   end

   always_ff @(posedge clock) begin
      base_u_ff  <= base_u_in;
      base_v_ff  <= base_v_in;
      ofs_u_ff   <= ofs_u_in;
      ofs_v_ff   <= ofs_v_in;
      s1_ua_ff   <= s1_ua_in;
      s1_va_ff   <= s1_va_in;
      s1_last_ff <= seq_last;
      rd_last_ff <= s1_last_ff;
      gather_ff  <= gather_in;
      if (move) begin
         rsp_low_ff  <= gather_ff[WORD_BITS-1:0];
         rsp_high_ff <= gather_ff[2*WORD_BITS-1:WORD_BITS];
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_row_word_low  = rsp_low_ff;
   assign rsp_row_word_high = rsp_high_ff;

endmodule

FILE: hw/rtl/mtss_checker.sv
// Port-level checks of the Morton texture span sampler, bound to its top level.
// Depends on mtss_pkg and morton_texture_span_sampler_macros.svh.
`timescale 1ns / 1ps
`include "morton_texture_span_sampler_macros.svh"

module mtss_checker (
   input logic                           clock,
   input logic                           reset,
   input logic                           req_valid,
   input logic                           req_ready,
   input logic [mtss_pkg::FUNC_BITS-1:0] req_func,
   input logic                           rsp_valid,
   input logic                           rsp_ready,
   input logic [mtss_pkg::WORD_BITS-1:0] rsp_row_word_low,
   input logic [mtss_pkg::WORD_BITS-1:0] rsp_row_word_high
);
   import mtss_pkg::*;

   logic row_taken;
   assign row_taken = req_valid && req_ready && (req_func == FUNC_ROW);

   // A result that is not taken stays put.
   `MTSS_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_row_word_low) && $stable(rsp_row_word_high))

   // Reset leaves no result pending.
   `MTSS_ASSERT_NEXT_ALWAYS(a_reset_empty, clock, reset, !rsp_valid)

   // A row holds the texture port, so neither a row nor a write follows it at once.
   `MTSS_ASSERT_NEXT(a_row_spacing, clock, reset, row_taken, !(req_valid && req_ready && (req_func == FUNC_ROW || req_func == FUNC_WRITE)))

endmodule

bind morton_texture_span_sampler mtss_checker u_mtss_checker (.*);

FILE: sim/testbench.sv
// Self-checking testbench for the Morton texture span sampler: writes texels, loads
// span starts and checks every sampled row against a behavioral predictor.
// Depends on mtss_pkg and morton_texture_span_sampler.
`timescale 1ns / 1ps

module testbench;
   import mtss_pkg::*;

   localparam int unsigned AXIS_BITS     = 10;
   localparam int unsigned TEXEL_COUNT   = 1 << (2 * AXIS_BITS);
   localparam int unsigned ITEM_TARGET   = 1750;
   localparam int unsigned SEGMENTS      = 6;
   localparam int unsigned SETTLE_CYCLES = 40;
   localparam logic [FUNC_BITS-1:0] FUNC_UNUSED = 2'd3;
   localparam logic [WORD_BITS-1:0] STEP_CORNERS [5] = '{
      32'h0000_0000, 32'h7fff_ffff, 32'h8000_0000, 32'hffff_ffff, 32'h0000_1000
   };

   typedef struct packed {
      logic [WORD_BITS-1:0] high;
      logic [WORD_BITS-1:0] low;
   } row_words_t;

   // Tracks steps, accumulators and texture contents, and keeps the rows still owed.
   class row_sampler_model;
      logic [WORD_BITS-1:0] step_pixel_u, step_pixel_v, step_row_u, step_row_v;
      logic [WORD_BITS-1:0] acc_u, acc_v;
      logic [VALUE_BITS-1:0] texels [int unsigned];
      row_words_t expected_rows [$];
      int unsigned mismatches, rows_compared, settings;

      function new();
         step_pixel_u = '0;
         step_pixel_v = '0;
         step_row_u = '0;
         step_row_v = '0;
         acc_u = '0;
         acc_v = '0;
         mismatches = 0;
         rows_compared = 0;
         settings = 0;
      endfunction

      function logic [WORD_BITS-1:0] spread(logic [WORD_BITS-1:0] x, int unsigned base);
         logic [WORD_BITS-1:0] r;
         r = '0;
         for (int i = 0; i < AXIS_BITS; i++)
            if (x[i]) r[base + 2 * i] = 1'b1;
         return r;
      endfunction

      function logic [WORD_BITS-1:0] u_lane(logic [WORD_BITS-1:0] lin);
         return (lin & FRAC_MASK) | spread(lin >> FRAC_BITS, FRAC_BITS);
      endfunction

      function logic [WORD_BITS-1:0] v_lane(logic [WORD_BITS-1:0] lin);
         return (lin & FRAC_MASK) | spread(lin >> FRAC_BITS, FRAC_BITS + 1);
      endfunction

      function logic [WORD_BITS-1:0] u_mask();
         return FRAC_MASK | spread('1, FRAC_BITS);
      endfunction

      function logic [WORD_BITS-1:0] v_mask();
         return FRAC_MASK | spread('1, FRAC_BITS + 1);
      endfunction

      // The fraction sum carries into the interleaved index, then the index wraps.
      function int unsigned texel_address(logic [WORD_BITS-1:0] ua, logic [WORD_BITS-1:0] va);
         logic [WORD_BITS-1:0] sum;
         sum = (ua & u_mask()) + (va & v_mask());
         return (sum >> FRAC_BITS) & (TEXEL_COUNT - 1);
      endfunction

      function void row_addresses(output int unsigned addr [TEXELS_PER_ROW]);
         logic [WORD_BITS-1:0] u, v;
         u = acc_u & u_mask();
         v = acc_v & v_mask();
         for (int k = 0; k < TEXELS_PER_ROW; k++)
            addr[k] = texel_address(u + (u_lane(step_pixel_u * 32'(k)) | U_PAD),
                                    v + (v_lane(step_pixel_v * 32'(k)) | V_PAD));
      endfunction

      function void apply_csr(csr_index_type index, logic [WORD_BITS-1:0] data);
         case (index)
            CSR_PIXEL_STEP_U: step_pixel_u = data;
            CSR_PIXEL_STEP_V: step_pixel_v = data;
            CSR_ROW_STEP_U:   step_row_u = data;
            CSR_ROW_STEP_V:   step_row_v = data;
         endcase
      endfunction

      function void note_request(logic [FUNC_BITS-1:0] f, logic [TEXEL_POS_BITS-1:0] tu,
                                 logic [TEXEL_POS_BITS-1:0] tv, logic [VALUE_BITS-1:0] value,
                                 logic [WORD_BITS-1:0] su, logic [WORD_BITS-1:0] sv);
         int unsigned addr [TEXELS_PER_ROW];
         row_words_t row;
         logic [WORD_BITS-1:0] u, v;
         case (f)
            FUNC_WRITE: texels[spread(tu, 0) | spread(tv, 1)] = value;
            FUNC_START: begin
               acc_u = u_lane(su);
               acc_v = v_lane(sv);
            end
            FUNC_ROW: begin
               row_addresses(addr);
               row = '0;
               for (int k = 0; k < TEXELS_PER_ROW; k++)
                  row[8 * k +: 8] = texels.exists(addr[k]) ? texels[addr[k]] : 8'h00;
               u = acc_u & u_mask();
               v = acc_v & v_mask();
               acc_u = (u + (u_lane(step_row_u) | U_PAD)) & u_mask();
               acc_v = (v + (v_lane(step_row_v) | V_PAD)) & v_mask();
               expected_rows.push_back(row);
            end
            default: ;
         endcase
      endfunction

      function void check_row(logic [WORD_BITS-1:0] low, logic [WORD_BITS-1:0] high);
         row_words_t want;
         if (expected_rows.size() == 0) begin
            $display("%0t: row with no request pending, low %h high %h", $time, low, high);
            mismatches++;
            return;
         end
         want = expected_rows.pop_front();
         rows_compared++;
         if (low !== want.low) begin
            $display("%0t: row_word_low expected %h actual %h", $time, want.low, low);
            mismatches++;
         end
         if (high !== want.high) begin
            $display("%0t: row_word_high expected %h actual %h", $time, want.high, high);
            mismatches++;
         end
      endfunction
   endclass

   logic clock;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   logic [FUNC_BITS-1:0] req_func = '0;
   logic [TEXEL_POS_BITS-1:0] req_texel_u = '0;
   logic [TEXEL_POS_BITS-1:0] req_texel_v = '0;
   logic [VALUE_BITS-1:0] req_texel_value = '0;
   logic signed [WORD_BITS-1:0] req_start_u = '0;
   logic signed [WORD_BITS-1:0] req_start_v = '0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   logic [WORD_BITS-1:0] rsp_row_word_low;
   logic [WORD_BITS-1:0] rsp_row_word_high;
   logic csr_valid = 1'b0;
   logic csr_ready;
   logic [CSR_INDEX_BITS-1:0] csr_index = '0;
   logic [WORD_BITS-1:0] csr_data = '0;

   int unsigned sender_idle = 0;
   int unsigned receiver_idle = 0;
   int unsigned requests_sent = 0;
   row_sampler_model sampler_model = new();

   morton_texture_span_sampler #(.AXIS_BITS(AXIS_BITS)) i_dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_func(req_func),
      .req_texel_u(req_texel_u),
      .req_texel_v(req_texel_v),
      .req_texel_value(req_texel_value),
      .req_start_u(req_start_u),
      .req_start_v(req_start_v),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_row_word_low(rsp_row_word_low),
      .rsp_row_word_high(rsp_row_word_high),
      .csr_valid(csr_valid),
      .csr_ready(csr_ready),
      .csr_index(csr_index),
      .csr_data(csr_data)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready)
            sampler_model.check_row(rsp_row_word_low, rsp_row_word_high);
         rsp_ready <= ($urandom_range(99) >= receiver_idle);
      end
   end

   task automatic send_request(input logic [FUNC_BITS-1:0] f,
                               input logic [TEXEL_POS_BITS-1:0] tu,
                               input logic [TEXEL_POS_BITS-1:0] tv,
                               input logic [VALUE_BITS-1:0] value,
                               input logic [WORD_BITS-1:0] su,
                               input logic [WORD_BITS-1:0] sv);
      while ($urandom_range(99) < sender_idle) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_func <= f;
      req_texel_u <= tu;
      req_texel_v <= tv;
      req_texel_value <= value;
      req_start_u <= su;
      req_start_v <= sv;
      do @(posedge clock); while (!req_ready);
      sampler_model.note_request(f, tu, tv, value, su, sv);
      if (f != FUNC_UNUSED) requests_sent++;
   endtask

   task automatic send_write(input logic [TEXEL_POS_BITS-1:0] tu,
                             input logic [TEXEL_POS_BITS-1:0] tv,
                             input logic [VALUE_BITS-1:0] value);
      send_request(FUNC_WRITE, tu, tv, value, $urandom, $urandom);
   endtask

   task automatic send_start(input logic [WORD_BITS-1:0] su, input logic [WORD_BITS-1:0] sv);
      send_request(FUNC_START, 10'($urandom_range(1023)), 10'($urandom_range(1023)),
                   8'($urandom_range(255)), su, sv);
   endtask

   // Texels that the row will touch but that hold nothing yet are written first.
   task automatic send_row();
      int unsigned addr [TEXELS_PER_ROW];
      logic [TEXEL_POS_BITS-1:0] tu, tv;
      sampler_model.row_addresses(addr);
      for (int k = 0; k < TEXELS_PER_ROW; k++) begin
         if (!sampler_model.texels.exists(addr[k])) begin
            tu = '0;
            tv = '0;
            for (int i = 0; i < AXIS_BITS; i++) begin
               tu[i] = addr[k][2 * i];
               tv[i] = addr[k][2 * i + 1];
            end
            send_write(tu, tv, 8'($urandom_range(255)));
         end
      end
      send_request(FUNC_ROW, 10'($urandom_range(1023)), 10'($urandom_range(1023)),
                   8'($urandom_range(255)), $urandom, $urandom);
   endtask

   task automatic program_steps(input logic [WORD_BITS-1:0] pu, input logic [WORD_BITS-1:0] pv,
                                input logic [WORD_BITS-1:0] ru, input logic [WORD_BITS-1:0] rv);
      csr_index_type names [4] = '{CSR_PIXEL_STEP_U, CSR_PIXEL_STEP_V,
                                   CSR_ROW_STEP_U, CSR_ROW_STEP_V};
      logic [WORD_BITS-1:0] values [4];
      values = '{pu, pv, ru, rv};
      for (int i = 0; i < 4; i++) begin
         csr_valid <= 1'b1;
         csr_index <= names[i];
         csr_data <= values[i];
         do @(posedge clock); while (!csr_ready);
         sampler_model.apply_csr(names[i], values[i]);
      end
      csr_valid <= 1'b0;
      sampler_model.settings++;
   endtask

   // Waits for every owed row, then lets trailing texel writes finish.
   task automatic drain();
      req_valid <= 1'b0;
      while (sampler_model.expected_rows.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   function automatic logic [WORD_BITS-1:0] pick_step();
      int unsigned r;
      r = $urandom_range(99);
      if (r < 45) return 32'($urandom_range(8 * 4096)) - 32'(4 * 4096);
      if (r < 65) return STEP_CORNERS[$urandom_range(4)];
      return $urandom;
   endfunction

   // Most spans start near the origin so that rows revisit written texels.
   function automatic logic [WORD_BITS-1:0] pick_start();
      if ($urandom_range(99) < 70)
         return (32'($urandom_range(63)) << FRAC_BITS) | 32'($urandom_range(4095));
      return $urandom;
   endfunction

   initial begin
      int unsigned r;
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // Corner texels, then spans that hit the fraction carry and coordinate wrap.
      send_write(10'd0, 10'd0, 8'hff);
      send_write(10'd1023, 10'd1023, 8'h00);
      send_write(10'd1023, 10'd0, 8'ha5);
      send_write(10'd0, 10'd1023, 8'h5a);
      send_start(32'h0000_0000, 32'h0000_0000);
      send_row();
      send_start(32'h7fff_ffff, 32'h7fff_ffff);
      send_row();
      send_start(32'h0000_0800, 32'h0000_0800);
      send_row();
      send_start(32'h8000_0000, 32'hffff_ffff);
      send_row();
      send_request(FUNC_UNUSED, 10'h3ff, 10'h3ff, 8'hff, 32'hffff_ffff, 32'hffff_ffff);
      send_row();

      for (int seg = 0; seg < SEGMENTS; seg++) begin
         drain();
         sender_idle = (seg < 2) ? 9 : (seg < 4) ? 75 : 0;
         receiver_idle = (seg < 2) ? 75 : (seg < 4) ? 9 : 0;
         if (seg == 0)
            program_steps(32'h7fff_ffff, 32'h8000_0000, 32'hffff_ffff, 32'h0000_1000);
         else if (seg == 3)
            program_steps(32'h8000_0000, 32'h7fff_ffff, 32'h0000_0000, 32'hffff_ffff);
         else
            program_steps(pick_step(), pick_step(), pick_step(), pick_step());
         send_start(pick_start(), pick_start());
         while (requests_sent < ITEM_TARGET * (seg + 1) / SEGMENTS) begin
            r = $urandom_range(99);
            if (r < 15) begin
               if ($urandom_range(99) < 70)
                  send_write(10'($urandom_range(63)), 10'($urandom_range(63)),
                             8'($urandom_range(255)));
               else
                  send_write(10'($urandom_range(1023)), 10'($urandom_range(1023)),
                             8'($urandom_range(255)));
            end else if (r < 30) begin
               send_start(pick_start(), pick_start());
            end else if (r < 95) begin
               send_row();
            end else begin
               send_request(FUNC_UNUSED, 10'($urandom_range(1023)), 10'($urandom_range(1023)),
                            8'($urandom_range(255)), $urandom, $urandom);
            end
         end
      end
      drain();

      $display("Run covered %0d requests, %0d rows compared, %0d step settings,",
               requests_sent, sampler_model.rows_compared, sampler_model.settings);
      $display("with both stall mixes on the two channels and one stall-free stretch.");
      if (sampler_model.mismatches == 0)
         $display("testbench: clean");
      else
         $display("testbench: errors");
      $finish;
   end

   initial begin
      #5000000;
      $display("Run stopped: rows still owed or requests not taken in time.");
      $display("testbench: errors");
      $finish;
   end

endmodule

FILE: filelist.f
+incdir+hw/rtl
hw/rtl/mtss_pkg.sv
hw/rtl/morton_texture_span_sampler.sv
hw/rtl/mtss_checker.sv
sim/testbench.sv
